// File: rtl/first_match_replace_stream_macros.svh
// assertion macros shared by the first_match_replace_stream rtl
// expects clk and rst_n in the scope where a macro is used
`ifndef FIRST_MATCH_REPLACE_STREAM_MACROS_SVH
`define FIRST_MATCH_REPLACE_STREAM_MACROS_SVH

`ifndef SYNTH
// plain clocked property, disabled during reset
`define FMRS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fmrs assertion failed");
// same-cycle implication
`define FMRS_ASSERT_IMP(lbl, ante, cons) \
  `FMRS_ASSERT(lbl, (ante) |-> (cons))
`else
`define FMRS_ASSERT(lbl, prop)
`define FMRS_ASSERT_IMP(lbl, ante, cons)
`endif

`endif

// File: rtl/fmrs_pkg.sv
// shared types and constants for the first_match_replace_stream block
// no dependencies
package fmrs_pkg;

  // configuration register indexes
  localparam logic [2:0] CFG_PAT_LO  = 3'd0;
  localparam logic [2:0] CFG_PAT_HI  = 3'd1;
  localparam logic [2:0] CFG_PAT_LEN = 3'd2;
  localparam logic [2:0] CFG_REP_LO  = 3'd3;
  localparam logic [2:0] CFG_REP_HI  = 3'd4;
  localparam logic [2:0] CFG_REP_LEN = 3'd5;

  // fixed register geometry
  localparam int REG_BYTES = 16;
  localparam int LEN_W     = 5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_REPL,
    S_DRAIN,
    S_END
  } fmrs_state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic emit_head;
    logic emit_rep;
    logic skip;
    logic start_match;
    logic finish;
  } fmrs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pass;
    logic match_ok;
    logic full_match;
    logic cnt_zero;
    logic cnt_one;
    logic rep_done;
    logic skip_zero;
    logic emit_go;
    logic fin_go;
    logic last;
    logic hold_v;
  } fmrs_stat_t;

endpackage

// File: rtl/fmrs_dpath.sv
// datapath: configuration registers, match buffer, replacement counters,
// hold stage and output register; uses fmrs_pkg and the assertion macros
`include "first_match_replace_stream_macros.svh"

module fmrs_dpath #(
  parameter int MAX_PATTERN = 16,
  parameter int MAX_REPLACE = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_addr,
  input  logic [63:0]       cfg_data,
  input  logic [7:0]        in_text_byte,
  input  logic              in_text_last,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_has_byte,
  output logic              out_last,
  output logic              out_replaced,
  input  fmrs_pkg::fmrs_cmd_t  cmd,
  output fmrs_pkg::fmrs_stat_t stat
);
  import fmrs_pkg::*;

  localparam int CW = $clog2(MAX_PATTERN + 1);
  localparam int RW = $clog2(MAX_REPLACE + 1);

  // configuration
  logic [8*REG_BYTES-1:0] pat_r, rep_r;
  logic [LEN_W-1:0]       plen_r, rlen_r;

  // text state
  logic [7:0]    mbuf_r [MAX_PATTERN];
  logic [7:0]    mbuf_nxt [MAX_PATTERN];
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] skip_r, skip_nxt;
  logic [RW-1:0] ridx_r, ridx_nxt;
  logic          done_r, done_nxt;
  logic          last_r;

  // hold stage and output register
  logic       hold_v_r, hold_v_nxt;
  logic [7:0] hold_byte_r;
  logic       hold_rep_r;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r;
  logic       out_has_r, out_last_r, out_rep_r;

  logic [CW-1:0] plen_eff, k_len;
  logic [RW-1:0] rlen_eff;
  logic          match_ok;
  logic [7:0]    rep_byte;
  logic          drop, emit, out_free, out_load;
  logic [7:0]    new_byte;

  assign cfg_ready = 1'b1;

  // effective lengths, clamped to the buffer sizes
  assign plen_eff = (plen_r > LEN_W'(MAX_PATTERN)) ? CW'(MAX_PATTERN) : CW'(plen_r);
  assign rlen_eff = (rlen_r > LEN_W'(MAX_REPLACE)) ? RW'(MAX_REPLACE) : RW'(rlen_r);
  assign k_len    = (cnt_r < plen_eff) ? cnt_r : plen_eff;

  // prefix compare of held bytes against the pattern
  always_comb begin
    match_ok = 1'b1;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((CW'(i) < k_len) && (mbuf_r[i] != pat_r[i*8 +: 8])) begin
        match_ok = 1'b0;
      end
    end
  end

  // replacement byte select
  always_comb begin
    rep_byte = 8'h00;
    for (int i = 0; i < MAX_REPLACE; i++) begin
      if (ridx_r == RW'(i)) begin
        rep_byte = rep_r[i*8 +: 8];
      end
    end
  end

  assign out_free = !out_valid_r || out_ready;
  assign emit     = cmd.emit_head || cmd.emit_rep;
  assign drop     = cmd.emit_head || (cmd.skip && (skip_r != '0));
  assign new_byte = cmd.emit_head ? mbuf_r[0] : rep_byte;
  assign out_load = (emit && hold_v_r) || (cmd.finish && (hold_v_r || last_r));

  // status to the controller
  always_comb begin
    stat.pass       = done_r || (plen_eff == '0);
    stat.match_ok   = match_ok;
    stat.full_match = cnt_r >= plen_eff;
    stat.cnt_zero   = cnt_r == '0;
    stat.cnt_one    = cnt_r == CW'(1);
    stat.rep_done   = ridx_r == rlen_eff;
    stat.skip_zero  = skip_r == '0;
    stat.emit_go    = !hold_v_r || out_free;
    stat.fin_go     = !(hold_v_r || last_r) || out_free;
    stat.last       = last_r;
    stat.hold_v     = hold_v_r;
  end

  // buffer shift and insert
  always_comb begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      mbuf_nxt[i] = mbuf_r[i];
      if (drop) begin
        mbuf_nxt[i] = (i < MAX_PATTERN - 1) ? mbuf_r[(i < MAX_PATTERN - 1) ? i + 1 : i]
                                            : mbuf_r[i];
      end
      if (cmd.load && (cnt_r == CW'(i))) begin
        mbuf_nxt[i] = in_text_byte;
      end
    end
  end

  // counters and flags
  always_comb begin
    cnt_nxt  = cnt_r;
    skip_nxt = skip_r;
    ridx_nxt = ridx_r;
    done_nxt = done_r;
    if (cmd.load) begin
      cnt_nxt = cnt_r + CW'(1);
    end
    if (drop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
    if (cmd.skip && (skip_r != '0)) begin
      skip_nxt = skip_r - CW'(1);
    end
    if (cmd.start_match) begin
      done_nxt = 1'b1;
      skip_nxt = plen_eff;
      ridx_nxt = '0;
    end
    if (cmd.emit_rep) begin
      ridx_nxt = ridx_r + RW'(1);
    end
    if (cmd.finish && last_r) begin
      cnt_nxt  = '0;
      done_nxt = 1'b0;
    end
  end

  // hold and output valid
  always_comb begin
    hold_v_nxt = hold_v_r;
    if (emit) begin
      hold_v_nxt = 1'b1;
    end else if (cmd.finish) begin
      hold_v_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r       <= '0;
      rep_r       <= '0;
      plen_r      <= '0;
      rlen_r      <= '0;
      cnt_r       <= '0;
      skip_r      <= '0;
      ridx_r      <= '0;
      done_r      <= 1'b0;
      last_r      <= 1'b0;
      hold_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      skip_r      <= skip_nxt;
      ridx_r      <= ridx_nxt;
      done_r      <= done_nxt;
      hold_v_r    <= hold_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.load) begin
        last_r <= in_text_last;
      end
      if (cfg_valid) begin
        unique case (cfg_addr)
          CFG_PAT_LO:  pat_r[63:0]   <= cfg_data;
          CFG_PAT_HI:  pat_r[127:64] <= cfg_data;
          CFG_PAT_LEN: plen_r        <= cfg_data[LEN_W-1:0];
          CFG_REP_LO:  rep_r[63:0]   <= cfg_data;
          CFG_REP_HI:  rep_r[127:64] <= cfg_data;
          CFG_REP_LEN: rlen_r        <= cfg_data[LEN_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_PATTERN; i++) begin
      mbuf_r[i] <= mbuf_nxt[i];
    end
    if (emit) begin
      hold_byte_r <= new_byte;
      hold_rep_r  <= done_r;
    end
    if (emit && hold_v_r) begin
      out_byte_r <= hold_byte_r;
      out_has_r  <= 1'b1;
      out_rep_r  <= hold_rep_r;
      out_last_r <= 1'b0;
    end else if (cmd.finish && hold_v_r) begin
      out_byte_r <= hold_byte_r;
      out_has_r  <= 1'b1;
      out_rep_r  <= hold_rep_r;
      out_last_r <= last_r;
    end else if (cmd.finish && last_r) begin
      // empty end marker
      out_byte_r <= 8'h00;
      out_has_r  <= 1'b0;
      out_rep_r  <= done_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_has_byte = out_has_r;
  assign out_last     = out_last_r;
  assign out_replaced = out_rep_r;

  // checks
  `FMRS_ASSERT(a_cnt_range, cnt_r <= CW'(MAX_PATTERN))
  `FMRS_ASSERT_IMP(a_out_slot, out_load, out_free)
  `FMRS_ASSERT_IMP(a_head_present, cmd.emit_head, cnt_r != '0)

endmodule

// File: rtl/fmrs_ctrl.sv
// controller state machine: sequences insert, compare, replacement,
// drain and close of each transaction; uses fmrs_pkg and the assertion macros
`include "first_match_replace_stream_macros.svh"

module fmrs_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  fmrs_pkg::fmrs_stat_t stat,
  output fmrs_pkg::fmrs_cmd_t  cmd
);
  import fmrs_pkg::*;

  fmrs_state_t state_r, state_nxt;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.pass ? S_DRAIN : S_CHECK;
        end
      end
      S_CHECK: begin
        priority if (!stat.match_ok) begin
          if (stat.emit_go && stat.cnt_one) begin
            state_nxt = S_END;
          end
        end else if (stat.full_match) begin
          state_nxt = S_REPL;
        end else begin
          state_nxt = stat.last ? S_DRAIN : S_END;
        end
      end
      S_REPL: begin
        if (stat.rep_done && stat.skip_zero) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (stat.cnt_zero || (stat.emit_go && stat.cnt_one)) begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        if (stat.fin_go) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHECK: begin
        cmd.emit_head   = !stat.match_ok && stat.emit_go;
        cmd.start_match = stat.match_ok && stat.full_match;
      end
      S_REPL: begin
        cmd.skip     = !stat.skip_zero;
        cmd.emit_rep = !stat.rep_done && stat.emit_go;
      end
      S_DRAIN: begin
        cmd.emit_head = !stat.cnt_zero && stat.emit_go;
      end
      S_END: begin
        cmd.finish = stat.fin_go;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // checks
  `FMRS_ASSERT_IMP(a_idle_hold_empty, state_r == S_IDLE, !stat.hold_v)
  `FMRS_ASSERT(a_one_source, !(cmd.emit_head && cmd.emit_rep))
  `FMRS_ASSERT(a_accept_leaves_idle, (in_valid && in_ready) |=> (state_r != S_IDLE))

endmodule

// File: rtl/first_match_replace_stream.sv
// top level of the first-occurrence find and replace stream editor
// depends on fmrs_pkg, fmrs_ctrl and fmrs_dpath
//
// Usage: text enters one byte per transaction on in_*, in_text_last on the
// final byte. Results leave on out_*, one byte per transaction, with
// out_has_byte low only for the empty end marker of a text that ends with
// nothing to emit, and out_last on the final result of the text.
// The cfg_* port writes the pattern, replacement and their lengths; it is
// always ready and should only be written while the block is idle.
// Sequence: a byte is taken in the idle state, then compared against the
// pattern or drained, one result at a time as the hold stage frees, and the
// transaction is then closed. A byte that completes a match also emits the
// replacement and skips the matched bytes before the held bytes that follow
// the pattern are drained.
// Results sit in a one-entry hold stage and reach the output register when
// the next result or the close of the transaction arrives.
// The state machine sequencing these steps sets the rate.
// Reset clears configuration, match state and both output stages.
// A stalled receiver holds out_* steady; the block keeps working until the
// hold stage is also full, then waits.

module first_match_replace_stream #(
  parameter int MAX_PATTERN = 16,
  parameter int MAX_REPLACE = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_text_byte,
  input  logic        in_text_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_has_byte,
  output logic        out_last,
  output logic        out_replaced
);
  import fmrs_pkg::*;

  fmrs_cmd_t  cmd;
  fmrs_stat_t stat;

  fmrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fmrs_dpath #(
    .MAX_PATTERN (MAX_PATTERN),
    .MAX_REPLACE (MAX_REPLACE)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_addr     (cfg_addr),
    .cfg_data     (cfg_data),
    .in_text_byte (in_text_byte),
    .in_text_last (in_text_last),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last),
    .out_replaced (out_replaced),
    .cmd          (cmd),
    .stat         (stat)
  );

endmodule
